// ===== hdl/tesp_pkg.sv =====
`default_nettype none

package tesp_pkg;

  localparam int CpW   = 21;
  localparam int KindW = 2;
  localparam int ActW  = 4;

  // Cluster kinds
  localparam logic [KindW-1:0] KIND_EMPTY  = 2'd0;
  localparam logic [KindW-1:0] KIND_SINGLE = 2'd1;

  // Result actions
  localparam logic [ActW-1:0] ACT_NONE     = 4'd0;
  localparam logic [ActW-1:0] ACT_PRINT    = 4'd1;
  localparam logic [ActW-1:0] ACT_ED0      = 4'd2;
  localparam logic [ActW-1:0] ACT_EL0      = 4'd6;
  localparam logic [ActW-1:0] ACT_OSC_DONE = 4'd9;

  typedef struct packed {
    logic [CpW-1:0]   first_codepoint;
    logic [KindW-1:0] cluster_kind;
  } tesp_item_t;

  typedef struct packed {
    logic [ActW-1:0] action;
    logic [CpW-1:0]  print_codepoint;
    logic            malformed;
  } tesp_result_t;

endpackage

`default_nettype wire

// ===== hdl/terminal_escape_sequence_parser.sv =====
`default_nettype none

// Terminal escape sequence parser. Each input item is one grapheme cluster
// (first codepoint plus a kind: empty, single or several codepoints) and
// produces exactly one result item: print, erase in display 0-3, erase in
// line 0-2, OSC done, or no action, with a malformed flag for sequences that
// were rejected. Throughput is one item per clock while the result side is
// not stalled. An accepted item is loaded into the input register, moves into
// the result register when that register is empty or being taken, and is on
// the result ports from then on. The limit is the parser state update in
// tesp_step, which every item must pass through before the next one can be
// decoded. No clearing pass follows reset; the block takes items as soon as
// reset is released.

module terminal_escape_sequence_parser (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [tesp_pkg::CpW-1:0]      in_first_codepoint,
  input  wire logic [tesp_pkg::KindW-1:0]    in_cluster_kind,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tesp_pkg::ActW-1:0]          out_action,
  output logic [tesp_pkg::CpW-1:0]           out_print_codepoint,
  output logic                               out_malformed
);

  logic                    s1_valid_r, s1_valid_nxt;
  tesp_pkg::tesp_item_t    s1_item_r;
  logic                    out_valid_r, out_valid_nxt;
  tesp_pkg::tesp_result_t  out_result_r;
  tesp_pkg::tesp_result_t  step_result;
  logic                    advance;
  logic                    in_acc;
  logic                    step_en;

  // Advance the result register whenever it is empty or being taken.
  assign advance  = !out_valid_r || !out_stall;
  // Hold the input register only while its item cannot move on.
  assign in_stall = s1_valid_r && !advance;
  assign in_acc   = in_valid && !in_stall;
  assign step_en  = s1_valid_r && advance;

  assign s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.first_codepoint <= in_first_codepoint;
      s1_item_r.cluster_kind    <= in_cluster_kind;
    end
    if (step_en) begin
      out_result_r <= step_result;
    end
  end

  // Decode the held item against the parser state and update that state.
  tesp_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .result  (step_result)
  );

  assign out_valid           = out_valid_r;
  assign out_action          = out_result_r.action;
  assign out_print_codepoint = out_result_r.print_codepoint;
  assign out_malformed       = out_result_r.malformed;

endmodule

`default_nettype wire

// ===== hdl/tesp_step.sv =====
`default_nettype none

module tesp_step (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step_en,
  input  wire tesp_pkg::tesp_item_t  item,
  output tesp_pkg::tesp_result_t     result
);

  localparam logic [3:0] ST_RAW  = 4'd0;
  localparam logic [3:0] ST_ESC  = 4'd1;
  localparam logic [3:0] ST_SS2  = 4'd2;
  localparam logic [3:0] ST_SS3  = 4'd3;
  localparam logic [3:0] ST_DCS  = 4'd4;
  localparam logic [3:0] ST_CSI  = 4'd5;
  localparam logic [3:0] ST_STR  = 4'd6;
  localparam logic [3:0] ST_OSC  = 4'd7;
  localparam logic [3:0] ST_SOS  = 4'd8;
  localparam logic [3:0] ST_PM   = 4'd9;
  localparam logic [3:0] ST_APC  = 4'd10;
  localparam logic [3:0] ST_KPAM = 4'd11;
  localparam logic [3:0] ST_KPNM = 4'd12;

  localparam logic [tesp_pkg::CpW-1:0] CP_ESC   = 21'h1B;
  localparam logic [tesp_pkg::CpW-1:0] CP_BEL   = 21'h07;
  localparam logic [tesp_pkg::CpW-1:0] CP_ST    = 21'h9C;
  localparam logic [tesp_pkg::CpW-1:0] CP_BSL   = 21'h5C;
  localparam logic [tesp_pkg::CpW-1:0] CP_FIN_L = 21'h40;
  localparam logic [tesp_pkg::CpW-1:0] CP_FIN_H = 21'h7E;
  localparam logic [tesp_pkg::CpW-1:0] CP_C1_L  = 21'h80;
  localparam logic [tesp_pkg::CpW-1:0] CP_C1_H  = 21'h9F;
  localparam logic [tesp_pkg::CpW-1:0] CP_DIG_L = 21'h30;
  localparam logic [tesp_pkg::CpW-1:0] CP_DIG_H = 21'h39;
  localparam logic [tesp_pkg::CpW-1:0] CP_J     = 21'h4A;
  localparam logic [tesp_pkg::CpW-1:0] CP_K     = 21'h4B;

  localparam logic [3:0] ED_MAX = 4'd3;
  localparam logic [3:0] EL_MAX = 4'd2;

  // {hit, target state}
  function automatic logic [4:0] esc_target(input logic [tesp_pkg::CpW-1:0] c);
    case (c)
      21'h4E:  return {1'b1, ST_SS2};
      21'h4F:  return {1'b1, ST_SS3};
      21'h50:  return {1'b1, ST_DCS};
      21'h5B:  return {1'b1, ST_CSI};
      21'h5C:  return {1'b1, ST_STR};
      21'h5D:  return {1'b1, ST_OSC};
      21'h58:  return {1'b1, ST_SOS};
      21'h5E:  return {1'b1, ST_PM};
      21'h5F:  return {1'b1, ST_APC};
      21'h3D:  return {1'b1, ST_KPAM};
      21'h3E:  return {1'b1, ST_KPNM};
      default: return {1'b0, ST_RAW};
    endcase
  endfunction

  function automatic logic [4:0] c1_target(input logic [tesp_pkg::CpW-1:0] c);
    case (c)
      21'h8E:  return {1'b1, ST_SS2};
      21'h8F:  return {1'b1, ST_SS3};
      21'h90:  return {1'b1, ST_DCS};
      21'h9B:  return {1'b1, ST_CSI};
      21'h9C:  return {1'b1, ST_STR};
      21'h9D:  return {1'b1, ST_OSC};
      21'h98:  return {1'b1, ST_SOS};
      21'h9E:  return {1'b1, ST_PM};
      21'h9F:  return {1'b1, ST_APC};
      default: return {1'b0, ST_RAW};
    endcase
  endfunction

  logic [3:0]                state_r, state_nxt;
  logic [1:0]                pcnt_r, pcnt_nxt;
  logic [tesp_pkg::CpW-1:0]  first_r, first_nxt;
  logic [tesp_pkg::CpW-1:0]  last_r, last_nxt;

  logic [tesp_pkg::CpW-1:0]  cp;
  logic                      present;
  logic                      multi;
  logic [3:0]                cur;
  logic [1:0]                add_cnt;
  logic [tesp_pkg::CpW-1:0]  add_first;
  logic                      digit_ok;
  logic [3:0]                erase_n;
  logic                      erase_bad;
  logic [4:0]                esc_hit;
  logic [4:0]                c1_hit;
  logic                      osc_end;

  always_comb begin
    cp      = item.first_codepoint;
    present = item.cluster_kind != tesp_pkg::KIND_EMPTY;
    multi   = item.cluster_kind != tesp_pkg::KIND_SINGLE;
    // keypad modes fall back to raw text and handle the same cluster there
    cur     = (state_r == ST_KPAM || state_r == ST_KPNM) ? ST_RAW : state_r;

    add_cnt   = (pcnt_r == 2'd2) ? 2'd2 : pcnt_r + 2'd1;
    add_first = (pcnt_r == 2'd0) ? cp : first_r;

    digit_ok  = first_r >= CP_DIG_L && first_r <= CP_DIG_H;
    erase_n   = (pcnt_r == 2'd0) ? 4'd0 : first_r[3:0];
    erase_bad = (pcnt_r > 2'd1) || (pcnt_r == 2'd1 && !digit_ok);

    esc_hit = esc_target(cp);
    c1_hit  = c1_target(cp);
    osc_end = cp == CP_BEL || cp == CP_ST ||
              (cp == CP_BSL && pcnt_r != 2'd0 && last_r == CP_ESC);

    state_nxt = state_r;
    pcnt_nxt  = pcnt_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    result    = '0;

    if (present) begin
      case (cur)
        ST_ESC: begin
          if (multi) begin
            state_nxt        = ST_RAW;
            result.malformed = 1'b1;
          end else begin
            pcnt_nxt         = 2'd0;
            first_nxt        = '0;
            last_nxt         = '0;
            state_nxt        = esc_hit[3:0];
            result.malformed = !esc_hit[4];
          end
        end
        ST_CSI: begin
          if (multi) begin
            state_nxt        = ST_RAW;
            result.malformed = 1'b1;
          end else if (cp >= CP_FIN_L && cp <= CP_FIN_H) begin
            state_nxt = ST_RAW;
            if (cp == CP_J) begin
              if (erase_bad || erase_n > ED_MAX) begin
                result.malformed = 1'b1;
              end else begin
                result.action = tesp_pkg::ACT_ED0 + erase_n;
              end
            end else if (cp == CP_K) begin
              if (erase_bad || erase_n > EL_MAX) begin
                result.malformed = 1'b1;
              end else begin
                result.action = tesp_pkg::ACT_EL0 + erase_n;
              end
            end
          end else begin
            pcnt_nxt  = add_cnt;
            first_nxt = add_first;
            last_nxt  = cp;
          end
        end
        ST_OSC: begin
          if (multi) begin
            state_nxt        = ST_RAW;
            result.malformed = 1'b1;
          end else if (osc_end) begin
            result.action = tesp_pkg::ACT_OSC_DONE;
            state_nxt     = (cp == CP_BSL) ? ST_STR : ST_RAW;
          end else begin
            pcnt_nxt  = add_cnt;
            first_nxt = add_first;
            last_nxt  = cp;
          end
        end
        ST_SS2, ST_SS3, ST_DCS, ST_STR, ST_SOS, ST_PM, ST_APC: begin
          // drop the cluster
          state_nxt = ST_RAW;
        end
        default: begin
          state_nxt = ST_RAW;
          if (!multi && cp == CP_ESC) begin
            state_nxt = ST_ESC;
          end else if (!multi && cp >= CP_C1_L && cp <= CP_C1_H) begin
            state_nxt        = c1_hit[3:0];
            result.malformed = !c1_hit[4];
          end else begin
            result.action          = tesp_pkg::ACT_PRINT;
            result.print_codepoint = cp;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RAW;
      pcnt_r  <= 2'd0;
      first_r <= '0;
      last_r  <= '0;
    end else if (step_en) begin
      state_r <= state_nxt;
      pcnt_r  <= pcnt_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  a_bad_no_action: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.malformed |-> result.action == tesp_pkg::ACT_NONE)
    else $error("malformed item carries an action");

  a_cp_only_print: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.action != tesp_pkg::ACT_PRINT |-> result.print_codepoint == '0)
    else $error("codepoint driven without print");

  a_esc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && state_r == ST_ESC && item.cluster_kind == tesp_pkg::KIND_SINGLE
    |=> pcnt_r == 2'd0 && first_r == '0 && last_r == '0)
    else $error("parameters not cleared after ESC");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.cluster_kind == tesp_pkg::KIND_EMPTY |=> $stable(state_r))
    else $error("empty cluster moved the parser state");

endmodule

`default_nettype wire

// ===== bench/terminal_escape_sequence_parser_test.sv =====
`timescale 1ns / 1ps

module terminal_escape_sequence_parser_test;

  // Kinds that the package leaves unnamed; both mean several codepoints
  localparam logic [tesp_pkg::KindW-1:0] KIND_MULTI     = 2'd2;
  localparam logic [tesp_pkg::KindW-1:0] KIND_MULTI_ALT = 2'd3;

  // Codepoints the parser reacts to
  localparam logic [tesp_pkg::CpW-1:0] CH_BEL    = 'h07;
  localparam logic [tesp_pkg::CpW-1:0] CH_ESC    = 'h1B;
  localparam logic [tesp_pkg::CpW-1:0] CH_BSLASH = "\\";
  localparam logic [tesp_pkg::CpW-1:0] CH_LBRACK = "[";
  localparam logic [tesp_pkg::CpW-1:0] CH_RBRACK = "]";
  localparam logic [tesp_pkg::CpW-1:0] CH_J      = "J";
  localparam logic [tesp_pkg::CpW-1:0] CH_K      = "K";
  localparam logic [tesp_pkg::CpW-1:0] CH_M      = "m";
  localparam logic [tesp_pkg::CpW-1:0] CH_0      = "0";
  localparam logic [tesp_pkg::CpW-1:0] CH_9      = "9";
  localparam logic [tesp_pkg::CpW-1:0] CH_SPACE  = " ";
  localparam logic [tesp_pkg::CpW-1:0] FINAL_LO  = 'h40;
  localparam logic [tesp_pkg::CpW-1:0] FINAL_HI  = 'h7E;
  localparam logic [tesp_pkg::CpW-1:0] C1_LO     = 'h80;
  localparam logic [tesp_pkg::CpW-1:0] C1_SS2    = 'h8E;
  localparam logic [tesp_pkg::CpW-1:0] C1_SS3    = 'h8F;
  localparam logic [tesp_pkg::CpW-1:0] C1_DCS    = 'h90;
  localparam logic [tesp_pkg::CpW-1:0] C1_SOS    = 'h98;
  localparam logic [tesp_pkg::CpW-1:0] C1_CSI    = 'h9B;
  localparam logic [tesp_pkg::CpW-1:0] C1_ST     = 'h9C;
  localparam logic [tesp_pkg::CpW-1:0] C1_OSC    = 'h9D;
  localparam logic [tesp_pkg::CpW-1:0] C1_PM     = 'h9E;
  localparam logic [tesp_pkg::CpW-1:0] C1_APC    = 'h9F;
  localparam logic [tesp_pkg::CpW-1:0] C1_HI     = 'h9F;
  localparam logic [tesp_pkg::CpW-1:0] CP_MAX    = 'h10FFFF;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1700;

  typedef enum logic [3:0] {
    PS_RAW, PS_ESC, PS_SS2, PS_SS3, PS_DCS, PS_CSI, PS_STR,
    PS_OSC, PS_SOS, PS_PM, PS_APC, PS_KPAM, PS_KPNM
  } parse_state_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [tesp_pkg::CpW-1:0]      in_first_codepoint;
  logic [tesp_pkg::KindW-1:0]    in_cluster_kind;
  logic                          out_valid;
  logic                          out_stall;
  logic [tesp_pkg::ActW-1:0]     out_action;
  logic [tesp_pkg::CpW-1:0]      out_print_codepoint;
  logic                          out_malformed;

  terminal_escape_sequence_parser u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_codepoint  (in_first_codepoint),
    .in_cluster_kind     (in_cluster_kind),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_print_codepoint (out_print_codepoint),
    .out_malformed       (out_malformed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the parser state, advanced once per accepted item
  parse_state_t             shadow_state = PS_RAW;
  logic [1:0]               shadow_count = '0;
  logic [tesp_pkg::CpW-1:0] shadow_first = '0;
  logic [tesp_pkg::CpW-1:0] shadow_last  = '0;

  // Actions still owed by the block, oldest first
  tesp_pkg::tesp_result_t expected_actions[$];

  int  error_count   = 0;
  int  items_sent    = 0;
  int  cycle_count   = 0;
  int  checked_count = 0;
  int  print_count   = 0;
  int  erase_count   = 0;
  int  osc_count     = 0;
  int  bad_count     = 0;
  bit  tx_idle_on    = 1'b0;
  bit  rx_idle_on    = 1'b0;
  // Set by a test to make the receiver hold off this many cycles
  int  rx_hold_len   = 0;

  // ESC followed by a single codepoint: look up the introducer
  function automatic bit esc_introducer(input logic [tesp_pkg::CpW-1:0] cp,
                                        output parse_state_t nxt);
    nxt = PS_RAW;
    if (cp[tesp_pkg::CpW-1:8] != '0) return 1'b0;
    case (cp[7:0])
      "N":  nxt = PS_SS2;
      "O":  nxt = PS_SS3;
      "P":  nxt = PS_DCS;
      "[":  nxt = PS_CSI;
      "\\": nxt = PS_STR;
      "]":  nxt = PS_OSC;
      "X":  nxt = PS_SOS;
      "^":  nxt = PS_PM;
      "_":  nxt = PS_APC;
      "=":  nxt = PS_KPAM;
      ">":  nxt = PS_KPNM;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // 8-bit C1 control in raw text
  function automatic bit c1_introducer(input logic [tesp_pkg::CpW-1:0] cp,
                                       output parse_state_t nxt);
    nxt = PS_RAW;
    case (cp)
      C1_SS2: nxt = PS_SS2;
      C1_SS3: nxt = PS_SS3;
      C1_DCS: nxt = PS_DCS;
      C1_CSI: nxt = PS_CSI;
      C1_ST:  nxt = PS_STR;
      C1_OSC: nxt = PS_OSC;
      C1_SOS: nxt = PS_SOS;
      C1_PM:  nxt = PS_PM;
      C1_APC: nxt = PS_APC;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void record_param(input logic [tesp_pkg::CpW-1:0] cp);
    if (shadow_count == 2'd0) shadow_first = cp;
    if (shadow_count < 2'd2) shadow_count = shadow_count + 2'd1;
    shadow_last = cp;
  endfunction

  // Erase with an optional single-digit parameter; n beyond max_n is rejected
  function automatic logic [tesp_pkg::ActW-1:0] erase_action(
      input logic [tesp_pkg::ActW-1:0] base, input int max_n, output bit bad);
    int n;
    n = 0;
    bad = 1'b0;
    if (shadow_count > 2'd1) begin
      bad = 1'b1;
      return tesp_pkg::ACT_NONE;
    end
    if (shadow_count == 2'd1) begin
      if (shadow_first < CH_0 || shadow_first > CH_9) begin
        bad = 1'b1;
        return tesp_pkg::ACT_NONE;
      end
      n = int'(shadow_first - CH_0);
    end
    if (n > max_n) begin
      bad = 1'b1;
      return tesp_pkg::ACT_NONE;
    end
    return base + tesp_pkg::ActW'(n);
  endfunction

  // Advance the shadow state by one cluster and return the action it causes
  function automatic tesp_pkg::tesp_result_t predict_cluster(
      input logic [tesp_pkg::CpW-1:0] cp, input logic [tesp_pkg::KindW-1:0] kind);
    tesp_pkg::tesp_result_t res;
    bit                     multi;
    bit                     again;
    bit                     bad;
    parse_state_t           nxt;
    res   = '0;
    bad   = 1'b0;
    multi = (kind != tesp_pkg::KIND_SINGLE);
    again = (kind != tesp_pkg::KIND_EMPTY);
    while (again) begin
      again = 1'b0;
      case (shadow_state)
        PS_ESC: begin
          if (multi) begin
            shadow_state = PS_RAW;
            bad = 1'b1;
          end else begin
            shadow_count = '0;
            shadow_first = '0;
            shadow_last  = '0;
            if (esc_introducer(cp, nxt)) begin
              shadow_state = nxt;
            end else begin
              shadow_state = PS_RAW;
              bad = 1'b1;
            end
          end
        end
        PS_CSI: begin
          if (multi) begin
            shadow_state = PS_RAW;
            bad = 1'b1;
          end else if (cp >= FINAL_LO && cp <= FINAL_HI) begin
            if (cp == CH_J) res.action = erase_action(tesp_pkg::ACT_ED0, 3, bad);
            else if (cp == CH_K) res.action = erase_action(tesp_pkg::ACT_EL0, 2, bad);
            shadow_state = PS_RAW;
          end else begin
            record_param(cp);
          end
        end
        PS_OSC: begin
          if (multi) begin
            shadow_state = PS_RAW;
            bad = 1'b1;
          end else if (cp == CH_BEL || cp == C1_ST ||
                       (cp == CH_BSLASH && shadow_count != 2'd0 && shadow_last == CH_ESC)) begin
            res.action   = tesp_pkg::ACT_OSC_DONE;
            shadow_state = (cp == CH_BSLASH) ? PS_STR : PS_RAW;
          end else begin
            record_param(cp);
          end
        end
        PS_SS2, PS_SS3, PS_DCS, PS_STR, PS_SOS, PS_PM, PS_APC: begin
          // one cluster swallowed silently
          shadow_state = PS_RAW;
        end
        PS_KPAM, PS_KPNM: begin
          // leave keypad mode and run the same cluster through raw text
          shadow_state = PS_RAW;
          again = 1'b1;
        end
        default: begin
          shadow_state = PS_RAW;
          if (!multi && cp == CH_ESC) begin
            shadow_state = PS_ESC;
          end else if (!multi && cp >= C1_LO && cp <= C1_HI) begin
            if (c1_introducer(cp, nxt)) shadow_state = nxt;
            else bad = 1'b1;
          end else begin
            res.action          = tesp_pkg::ACT_PRINT;
            res.print_codepoint = cp;
          end
        end
      endcase
    end
    res.malformed = bad;
    return res;
  endfunction

  // Offer one cluster, hold it until the block takes it, then log its action.
  // Call at a rising edge.
  task automatic send_cluster(input logic [tesp_pkg::CpW-1:0] cp,
                              input logic [tesp_pkg::KindW-1:0] kind);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_first_codepoint <= cp;
    in_cluster_kind    <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_actions.push_back(predict_cluster(cp, kind));
    items_sent++;
  endtask

  task automatic send_char(input logic [tesp_pkg::CpW-1:0] cp);
    send_cluster(cp, tesp_pkg::KIND_SINGLE);
  endtask

  // Stop offering and wait until every owed action has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_actions.size() != 0) @(posedge clk);
  endtask

  function automatic logic [tesp_pkg::CpW-1:0] any_codepoint();
    return tesp_pkg::CpW'($urandom_range(0, CP_MAX));
  endfunction

  function automatic logic [tesp_pkg::KindW-1:0] any_multi_kind();
    return ($urandom_range(0, 1) != 0) ? KIND_MULTI : KIND_MULTI_ALT;
  endfunction

  // Mostly small digits so that erase variants hit, plus the odd junk parameter
  function automatic logic [tesp_pkg::CpW-1:0] pick_csi_param();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return CH_0 + tesp_pkg::CpW'($urandom_range(0, 4));
    if (r < 16) return CH_0 + tesp_pkg::CpW'($urandom_range(5, 9));
    if (r < 18) return tesp_pkg::CpW'($urandom_range(0, 'h3F));
    return tesp_pkg::CpW'($urandom_range('h7F, CP_MAX));
  endfunction

  // One random sequence: mostly well-formed escapes with random content,
  // with breaks and plain noise mixed in
  task automatic send_random_sequence();
    int pick;
    int n;
    logic [tesp_pkg::CpW-1:0] intro [11];
    pick = $urandom_range(0, 19);
    intro = '{"N", "O", "P", "[", "\\", "]", "X", "^", "_", "=", ">"};
    case (pick)
      0, 1, 2: begin
        // plain text with the odd empty or multi cluster
        n = $urandom_range(1, 4);
        repeat (n) begin
          if ($urandom_range(0, 4) == 0) send_cluster(any_codepoint(), any_multi_kind());
          else if ($urandom_range(0, 9) == 0)
            send_cluster(any_codepoint(), tesp_pkg::KIND_EMPTY);
          else send_char(tesp_pkg::CpW'($urandom_range(CH_SPACE, 'h7E)));
        end
      end
      3, 4, 5, 6, 7, 8: begin
        // CSI erase, entered by ESC [ or the C1 form
        if ($urandom_range(0, 3) == 0) begin
          send_char(C1_CSI);
        end else begin
          send_char(CH_ESC);
          send_char(CH_LBRACK);
        end
        n = $urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 1;
        repeat (n) send_char(pick_csi_param());
        if ($urandom_range(0, 15) == 0) send_cluster(any_codepoint(), any_multi_kind());
        else if ($urandom_range(0, 15) == 0)
          send_cluster(any_codepoint(), tesp_pkg::KIND_EMPTY);
        case ($urandom_range(0, 9))
          0:       send_char(CH_M);
          1:       send_char(tesp_pkg::CpW'($urandom_range(FINAL_LO, FINAL_HI)));
          2, 3, 4: send_char(CH_K);
          default: send_char(CH_J);
        endcase
      end
      9, 10, 11: begin
        // OSC with random text, then a terminator, a lone backslash or a breaking multi cluster
        if ($urandom_range(0, 3) == 0) begin
          send_char(C1_OSC);
        end else begin
          send_char(CH_ESC);
          send_char(CH_RBRACK);
        end
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) send_char(CH_ESC);
          else send_char(($urandom_range(0, 2) == 0)
                         ? any_codepoint()
                         : tesp_pkg::CpW'($urandom_range(CH_SPACE, 'h7E)));
        end
        case ($urandom_range(0, 7))
          0:       send_cluster(any_codepoint(), any_multi_kind());
          1, 2:    send_char(C1_ST);
          3, 4:    send_char(CH_BEL);
          5:       send_char(CH_BSLASH);
          default: begin
            send_char(CH_ESC);
            send_char(CH_BSLASH);
          end
        endcase
      end
      12, 13, 14, 15: begin
        // ESC with a known or random introducer, then whatever follows
        send_char(CH_ESC);
        case ($urandom_range(0, 5))
          0:       send_cluster(any_codepoint(), any_multi_kind());
          1:       send_char(tesp_pkg::CpW'($urandom_range(0, 'h7F)));
          default: send_char(intro[$urandom_range(0, 10)]);
        endcase
        send_cluster(($urandom_range(0, 1) != 0) ? any_codepoint()
                                                 : tesp_pkg::CpW'($urandom_range(0, C1_HI)),
                     ($urandom_range(0, 5) == 0) ? any_multi_kind()
                                                 : tesp_pkg::KIND_SINGLE);
      end
      16, 17: begin
        // C1 control, known or not, and the cluster after it
        send_char(tesp_pkg::CpW'($urandom_range(C1_LO, C1_HI)));
        send_cluster(tesp_pkg::CpW'($urandom_range(0, 'hFF)), tesp_pkg::KIND_SINGLE);
      end
      default: begin
        send_cluster(any_codepoint(), tesp_pkg::KindW'($urandom_range(0, 3)));
      end
    endcase
  endtask

  // --- directed tests ---------------------------------------------------

  task automatic test_raw_text();
    send_char('0);                          // lowest codepoint prints
    send_cluster(CP_MAX, KIND_MULTI_ALT);   // top codepoint, odd kind acts as several
    send_cluster(CH_ESC, KIND_MULTI);       // ESC inside a multi cluster just prints
    send_cluster(any_codepoint(), tesp_pkg::KIND_EMPTY);
    send_char(CH_BEL);                      // C0 control prints like text
    send_char(C1_LO);                       // unknown C1: flagged, nothing printed
  endtask

  task automatic test_csi_erase();
    send_char(CH_ESC);
    send_char(CH_LBRACK);
    send_char("3");
    send_char(CH_J);                        // erase display 3
    // C1 CSI keeps the leftover '3', so K sees n out of range
    send_char(C1_CSI);
    send_char(CH_K);
    send_char(CH_ESC);
    send_char(CH_LBRACK);
    send_char("1");
    send_char("2");
    send_char(CH_J);                        // two parameters: rejected
    send_char(CH_ESC);
    send_char(CH_LBRACK);
    send_char(CH_M);                        // other final byte: quietly ignored
  endtask

  task automatic test_osc_and_strings();
    send_char(CH_ESC);
    send_char(CH_RBRACK);
    send_char(CH_ESC);
    send_char(CH_BSLASH);                   // ESC \ ends OSC, lands in ST
    send_char("x");                         // swallowed by ST
    send_char(C1_OSC);
    send_cluster("a", KIND_MULTI);          // multi cluster breaks OSC
  endtask

  task automatic test_escape_modes();
    send_char(CH_ESC);
    send_char("=");
    send_char("A");                         // keypad mode hands A back to raw text
    send_char(CH_ESC);
    send_char("Z");                         // unknown introducer
    send_char(CH_ESC);
    send_cluster("[", KIND_MULTI);          // multi cluster after ESC
  endtask

  // Receiver holds off long enough for the block to fill and stall the sender
  task automatic test_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_len = 300;
    repeat (12) send_random_sequence();
    wait_for_results();
  endtask

  task automatic test_random_stream();
    int stop_at;
    int seq;
    stop_at = items_sent + RANDOM_ITEMS;
    seq = 0;
    while (items_sent < stop_at) begin
      // switch idling on and off in stretches
      if (seq % 30 == 0) begin
        tx_idle_on = ($urandom_range(0, 2) != 0);
        rx_idle_on = ($urandom_range(0, 2) != 0);
      end
      if ($urandom_range(0, 80) == 0) wait_for_results();
      send_random_sequence();
      seq++;
    end
  endtask

  // --- result side ------------------------------------------------------

  // Receiver: random stall per result, or one long hold when a test asks
  initial begin : result_sink
    int gap;
    int hold;
    gap = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        hold = rx_hold_len;
        rx_hold_len = 0;
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        if (out_valid && !out_stall) gap = rx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
          out_stall <= 1'b1;
          gap--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Compare every accepted action with the oldest one owed
  always @(posedge clk) begin : action_check
    tesp_pkg::tesp_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_actions.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result action=%0d cp=%h malformed=%0b", $time,
                 out_action, out_print_codepoint, out_malformed);
      end else begin
        want = expected_actions.pop_front();
        checked_count++;
        if (out_action != want.action) begin
          error_count++;
          $display("%0t: action expected %0d actual %0d", $time, want.action, out_action);
        end
        if (out_print_codepoint != want.print_codepoint) begin
          error_count++;
          $display("%0t: print_codepoint expected %h actual %h", $time,
                   want.print_codepoint, out_print_codepoint);
        end
        if (out_malformed != want.malformed) begin
          error_count++;
          $display("%0t: malformed expected %0b actual %0b", $time,
                   want.malformed, out_malformed);
        end
        if (want.action == tesp_pkg::ACT_PRINT) print_count++;
        if (want.action >= tesp_pkg::ACT_ED0 && want.action < tesp_pkg::ACT_OSC_DONE)
          erase_count++;
        if (want.action == tesp_pkg::ACT_OSC_DONE) osc_count++;
        if (want.malformed) bad_count++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d actions outstanding", $time, expected_actions.size());
      $display("terminal_escape_sequence_parser verification failed");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_first_codepoint <= '0;
    in_cluster_kind    <= tesp_pkg::KIND_EMPTY;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    test_raw_text();
    test_csi_erase();
    test_osc_and_strings();
    test_escape_modes();
    test_backpressure();
    test_random_stream();

    wait_for_results();
    // keep the clock running so that any stray result shows on the output
    repeat (8) @(posedge clk);

    $display("Sent %0d clusters, checked %0d actions in %0d cycles", items_sent,
             checked_count, cycle_count);
    $display("  prints %0d, erases %0d, osc done %0d, malformed %0d", print_count,
             erase_count, osc_count, bad_count);
    if (error_count == 0) begin
      $display("terminal_escape_sequence_parser verification clean");
    end else begin
      $display("terminal_escape_sequence_parser verification failed");
    end
    $finish;
  end

endmodule
